FILE: rtl/r2y_pkg.sv
// Shared types, constants and helper functions of the RGB to planar YUV 4:2:0 converter.
`timescale 1ns / 1ps
`default_nettype none

package r2y_pkg;

  // Default frame size limits, handed down as top level parameter defaults.
  localparam int unsigned DEF_MAX_WIDTH  = 4096;
  localparam int unsigned DEF_MAX_HEIGHT = 4096;

  // Configuration port.
  localparam int unsigned CFG_W     = 13;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned DIM_W     = CFG_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RST = 13'd480;

  // Payload widths.
  localparam int unsigned PIX_W         = 8;
  localparam int unsigned LUMA_ADDR_W   = 24;
  localparam int unsigned CHROMA_ADDR_W = 25;

  // Q16 color coefficients (magnitudes; signs are applied in the datapath).
  localparam int unsigned SUM_W = 26;
  localparam logic [15:0] Q_YR  = 16'd19595;
  localparam logic [15:0] Q_YG  = 16'd38470;
  localparam logic [15:0] Q_YB  = 16'd7471;
  localparam logic [15:0] Q_UR  = 16'd9634;
  localparam logic [15:0] Q_UG  = 16'd18940;
  localparam logic [15:0] Q_UB  = 16'd28574;
  localparam logic [15:0] Q_VR  = 16'd40305;
  localparam logic [15:0] Q_VG  = 16'd33751;
  localparam logic [15:0] Q_VB  = 16'd6554;
  localparam logic [SUM_W-1:0] Q_OFS = 26'd8388608;

  // Address side results that travel from the address generator to the output register.
  typedef struct packed {
    logic [LUMA_ADDR_W-1:0]   luma_addr;
    logic                     chroma_valid;
    logic [CHROMA_ADDR_W-1:0] u_addr;
    logic [CHROMA_ADDR_W-1:0] v_addr;
    logic                     frame_last;
  } addr_t;

  // Effective dimension: bit 0 cleared, then limited to 2..max (max also made even).
  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v,
                                               input int unsigned maxv);
    logic [DIM_W-1:0] m;
    logic [DIM_W-1:0] r;
    m = DIM_W'(maxv) & ~DIM_W'(1);
    if (m < DIM_W'(2)) m = DIM_W'(2);
    r = {1'b0, v[CFG_W-1:1], 1'b0};
    if (r < DIM_W'(2)) r = DIM_W'(2);
    if (r > m) r = m;
    return r;
  endfunction

  // Truncate a Q16 sum to an integer and saturate it to 0..255.
  function automatic logic [PIX_W-1:0] sat_q16(input logic signed [SUM_W-1:0] s);
    logic [PIX_W-1:0] t;
    if (s[SUM_W-1]) begin
      t = '0;
    end else if (s[SUM_W-2:16+PIX_W] != '0) begin
      t = '1;
    end else begin
      t = s[16+PIX_W-1:16];
    end
    return t;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/r2y_if.sv
// Valid/ready channel interfaces for source pixels and converted results.
`timescale 1ns / 1ps
`default_nettype none

interface r2y_pix_if;
  import r2y_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red;
  logic [PIX_W-1:0] green;
  logic [PIX_W-1:0] blue;

  modport source(output valid, red, green, blue, input ready);
  modport sink(input valid, red, green, blue, output ready);
endinterface

interface r2y_yuv_if;
  import r2y_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [PIX_W-1:0]         luma;
  logic [LUMA_ADDR_W-1:0]   luma_addr;
  logic                     chroma_valid;
  logic [PIX_W-1:0]         chroma_u;
  logic [PIX_W-1:0]         chroma_v;
  logic [CHROMA_ADDR_W-1:0] u_addr;
  logic [CHROMA_ADDR_W-1:0] v_addr;
  logic                     frame_last;

  modport source(output valid, luma, luma_addr, chroma_valid, chroma_u, chroma_v,
                 u_addr, v_addr, frame_last, input ready);
  modport sink(input valid, luma, luma_addr, chroma_valid, chroma_u, chroma_v,
               u_addr, v_addr, frame_last, output ready);
endinterface

`default_nettype wire

FILE: rtl/rgb_to_yuv420_planar_core.sv
// Top level of the RGB to planar YUV 4:2:0 converter with its output register.
//
// Usage: source pixels enter on in_pix, one RGB item per pixel, in bottom-up order
// (last source row first, left to right within a row). Each item yields exactly one
// result item on out_yuv: the luma byte with its Y plane offset, and on pixels whose
// source row and column are both even also U and V bytes with their offsets in the
// U plane (base width*height) and V plane (base width*height*5/4).
// frame_last marks the last pixel of a frame, after which addressing starts over.
// Frame size is set through cfg_we/cfg_index/cfg_wdata while the block is idle;
// any write restarts the frame. Dimensions are forced even and into 2..MAX.
// Each result is registered: it is valid on the clock after its pixel is taken.
// Throughput is one item per cycle; the color math is constant multiplies and the
// address path is counter adds, all between the input and the result register.
// If the receiver stalls, the result register holds its item and in_pix.ready
// drops only while that register is full and out_yuv.ready is low.
// Reset (rst_n low, synchronous) loads 640 x 480 and empties the result register.
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_yuv420_planar_core #(
  parameter int unsigned MAX_WIDTH  = r2y_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = r2y_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [r2y_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [r2y_pkg::CFG_W-1:0]     cfg_wdata,
  r2y_pix_if.sink                       in_pix,
  r2y_yuv_if.source                     out_yuv
);
  import r2y_pkg::*;

  logic             in_ready;
  logic             advance;
  addr_t            addr;
  logic [PIX_W-1:0] luma;
  logic [PIX_W-1:0] chroma_u;
  logic [PIX_W-1:0] chroma_v;

  logic             out_valid_r, out_valid_nxt;
  addr_t            addr_r;
  logic [PIX_W-1:0] luma_r;
  logic [PIX_W-1:0] chroma_u_r;
  logic [PIX_W-1:0] chroma_v_r;

  // A new item can enter whenever the result register is empty or being drained.
  assign in_ready     = !out_valid_r || out_yuv.ready;
  assign in_pix.ready = in_ready;
  assign advance      = in_pix.valid && in_ready;

  r2y_addr #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_addr (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .advance  (advance),
    .addr     (addr)
  );

  r2y_color u_color (
    .red      (in_pix.red),
    .green    (in_pix.green),
    .blue     (in_pix.blue),
    .chroma_en(addr.chroma_valid),
    .luma     (luma),
    .chroma_u (chroma_u),
    .chroma_v (chroma_v)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_yuv.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload is loaded only when an item is taken, so a stalled result holds steady.
  always_ff @(posedge clk) begin
    if (advance) begin
      addr_r     <= addr;
      luma_r     <= luma;
      chroma_u_r <= chroma_u;
      chroma_v_r <= chroma_v;
    end
  end

  assign out_yuv.valid        = out_valid_r;
  assign out_yuv.luma         = luma_r;
  assign out_yuv.luma_addr    = addr_r.luma_addr;
  assign out_yuv.chroma_valid = addr_r.chroma_valid;
  assign out_yuv.chroma_u     = chroma_u_r;
  assign out_yuv.chroma_v     = chroma_v_r;
  assign out_yuv.u_addr       = addr_r.u_addr;
  assign out_yuv.v_addr       = addr_r.v_addr;
  assign out_yuv.frame_last   = addr_r.frame_last;

endmodule

`default_nettype wire

FILE: rtl/r2y_color.sv
// Fixed point RGB to Y, U, V conversion with truncation and saturation.
`timescale 1ns / 1ps
`default_nettype none

module r2y_color (
  input  logic [r2y_pkg::PIX_W-1:0] red,
  input  logic [r2y_pkg::PIX_W-1:0] green,
  input  logic [r2y_pkg::PIX_W-1:0] blue,
  input  logic                      chroma_en,
  output logic [r2y_pkg::PIX_W-1:0] luma,
  output logic [r2y_pkg::PIX_W-1:0] chroma_u,
  output logic [r2y_pkg::PIX_W-1:0] chroma_v
);
  import r2y_pkg::*;

  logic [SUM_W-1:0]        y_sum;
  logic [SUM_W-1:0]        u_pos;
  logic [SUM_W-1:0]        u_neg;
  logic [SUM_W-1:0]        v_pos;
  logic [SUM_W-1:0]        v_neg;
  logic signed [SUM_W-1:0] u_sum;
  logic signed [SUM_W-1:0] v_sum;

  // Every term is a small constant product; the sums stay well inside SUM_W bits.
  assign y_sum = SUM_W'(red) * SUM_W'(Q_YR) + SUM_W'(green) * SUM_W'(Q_YG)
               + SUM_W'(blue) * SUM_W'(Q_YB);
  assign u_pos = Q_OFS + SUM_W'(blue) * SUM_W'(Q_UB);
  assign u_neg = SUM_W'(red) * SUM_W'(Q_UR) + SUM_W'(green) * SUM_W'(Q_UG);
  assign v_pos = Q_OFS + SUM_W'(red) * SUM_W'(Q_VR);
  assign v_neg = SUM_W'(green) * SUM_W'(Q_VG) + SUM_W'(blue) * SUM_W'(Q_VB);
  assign u_sum = $signed(u_pos) - $signed(u_neg);
  assign v_sum = $signed(v_pos) - $signed(v_neg);

  assign luma     = sat_q16($signed(y_sum));
  assign chroma_u = chroma_en ? sat_q16(u_sum) : '0;
  assign chroma_v = chroma_en ? sat_q16(v_sum) : '0;

endmodule

`default_nettype wire

FILE: rtl/r2y_addr.sv
// Frame position tracking and planar buffer address generation.
`timescale 1ns / 1ps
`default_nettype none

module r2y_addr #(
  parameter int unsigned MAX_WIDTH  = r2y_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = r2y_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [r2y_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [r2y_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          advance,
  output r2y_pkg::addr_t                addr
);
  import r2y_pkg::*;

  localparam int unsigned EWW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned EHW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned CW  = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RW  = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned PW  = EWW + EHW;
  localparam int unsigned XW  = (PW > CHROMA_ADDR_W) ? PW : CHROMA_ADDR_W;

  localparam logic [EWW-1:0] W_RST = EWW'(eff_dim(IMAGE_WIDTH_RST, MAX_WIDTH));
  localparam logic [EHW-1:0] H_RST = EHW'(eff_dim(IMAGE_HEIGHT_RST, MAX_HEIGHT));
  localparam logic [PW-1:0]  PLANE_RST = PW'(W_RST) * PW'(H_RST);
  localparam logic [RW-1:0]  ROW_RST = RW'(H_RST - EHW'(1));

  logic [EWW-1:0]           w_eff_r, w_eff_nxt;
  logic [EHW-1:0]           h_eff_r, h_eff_nxt;
  logic [PW-1:0]            plane_r, plane_nxt;
  logic [CW-1:0]            col_r, col_nxt;
  logic [RW-1:0]            row_r, row_nxt;
  logic [LUMA_ADDR_W-1:0]   luma_cnt_r, luma_cnt_nxt;
  logic [CHROMA_ADDR_W-1:0] chroma_cnt_r, chroma_cnt_nxt;

  logic          col_end;
  logic          chroma;
  logic          last;
  logic [XW-1:0] plane_x;
  logic [XW-1:0] u_full;
  logic [XW-1:0] v_full;

  assign col_end = (col_r == CW'(w_eff_r - EWW'(1)));
  assign chroma  = !row_r[0] && !col_r[0];
  assign last    = (row_r == '0) && col_end;

  // The counters wrap at their address widths, which matches the masked addresses.
  assign plane_x = XW'(plane_r);
  assign u_full  = plane_x + XW'(chroma_cnt_r);
  assign v_full  = plane_x + (plane_x >> 2) + XW'(chroma_cnt_r);

  assign addr.luma_addr    = luma_cnt_r;
  assign addr.chroma_valid = chroma;
  assign addr.u_addr       = chroma ? u_full[CHROMA_ADDR_W-1:0] : '0;
  assign addr.v_addr       = chroma ? v_full[CHROMA_ADDR_W-1:0] : '0;
  assign addr.frame_last   = last;

  always_comb begin
    w_eff_nxt      = w_eff_r;
    h_eff_nxt      = h_eff_r;
    plane_nxt      = plane_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    luma_cnt_nxt   = luma_cnt_r;
    chroma_cnt_nxt = chroma_cnt_r;
    if (cfg_we) begin
      // Any register write restarts the frame with the new dimensions.
      if (cfg_index == REG_IMAGE_WIDTH) begin
        w_eff_nxt = EWW'(eff_dim(cfg_wdata, MAX_WIDTH));
      end
      if (cfg_index == REG_IMAGE_HEIGHT) begin
        h_eff_nxt = EHW'(eff_dim(cfg_wdata, MAX_HEIGHT));
      end
      plane_nxt      = PW'(w_eff_nxt) * PW'(h_eff_nxt);
      col_nxt        = '0;
      row_nxt        = RW'(h_eff_nxt - EHW'(1));
      luma_cnt_nxt   = '0;
      chroma_cnt_nxt = '0;
    end else if (advance) begin
      if (last) begin
        col_nxt        = '0;
        row_nxt        = RW'(h_eff_r - EHW'(1));
        luma_cnt_nxt   = '0;
        chroma_cnt_nxt = '0;
      end else begin
        luma_cnt_nxt = luma_cnt_r + LUMA_ADDR_W'(1);
        if (chroma) begin
          chroma_cnt_nxt = chroma_cnt_r + CHROMA_ADDR_W'(1);
        end
        if (col_end) begin
          col_nxt = '0;
          row_nxt = row_r - RW'(1);
        end else begin
          col_nxt = col_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_eff_r      <= W_RST;
      h_eff_r      <= H_RST;
      plane_r      <= PLANE_RST;
      col_r        <= '0;
      row_r        <= ROW_RST;
      luma_cnt_r   <= '0;
      chroma_cnt_r <= '0;
    end else begin
      w_eff_r      <= w_eff_nxt;
      h_eff_r      <= h_eff_nxt;
      plane_r      <= plane_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      luma_cnt_r   <= luma_cnt_nxt;
      chroma_cnt_r <= chroma_cnt_nxt;
    end
  end

endmodule

`default_nettype wire
